// ===== src/biquad_pkg.sv =====
// Shared codes, constants and control types for the cascaded biquad filter.
package biquad_pkg;

    // Item kinds carried on the input tuser
    localparam int          OP_W      = 2;
    localparam logic [1:0]  OP_SAMPLE = 2'd0;
    localparam logic [1:0]  OP_COEF   = 2'd1;
    localparam logic [1:0]  OP_CLEAR  = 2'd2;

    // Fixed field widths of the input item
    localparam int SECT_FIELD_W = 3;
    localparam int SLOT_FIELD_W = 3;
    localparam int COUNT_W      = 4;

    // Coefficient slots per section, and their term order in the MAC sequence
    localparam int          SLOTS     = 5;
    localparam logic [2:0]  TERM_GAIN = 3'd0;
    localparam logic [2:0]  TERM_IN1  = 3'd1;
    localparam logic [2:0]  TERM_IN2  = 3'd2;
    localparam logic [2:0]  TERM_OUT1 = 3'd3;
    localparam logic [2:0]  TERM_OUT2 = 3'd4;

    // Register map indexes (byte address is 4 times the index)
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_x;        // latch the incoming sample (or zero when disabled)
        logic       coef_wr;       // write one coefficient word
        logic       hist_clr;      // clear all history entries
        logic       issue;         // issue one MAC term
        logic [2:0] term;          // which term is issued
        logic       acc_clr;       // clear the accumulator
        logic       round_en;      // round and clamp the accumulator into y
        logic       wr_y;          // store y into history and pass it on as x
        logic       phase_toggle;  // flip the history phase
        logic       out_load;      // move the result into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;            // output register can take a result this cycle
        logic phase;               // current history phase
    } status_t;

endpackage

// ===== src/biquad_ctrl.sv =====
// Sequencer for the cascaded biquad filter: decodes items and steps the sections.
module biquad_ctrl #(
    parameter int MAX_SECTIONS = 8,
    parameter int SEC_W        = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [biquad_pkg::OP_W-1:0]  op,
    input  logic                         cfg_enable,
    input  logic [biquad_pkg::COUNT_W-1:0] cfg_count,
    input  biquad_pkg::status_t          status,
    output biquad_pkg::cmd_t             cmd,
    output logic [SEC_W-1:0]             sec_idx
);
    import biquad_pkg::*;

    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [2:0] DRAIN_LAST = 3'd1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ISSUE  = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [SEC_W-1:0]  last_reg, last_next;

    logic [CW-1:0]     cnt_ext;
    logic [CW-1:0]     n_eff;
    logic              accept;

    // Active section count, saturated to the build size
    assign cnt_ext = CW'(cfg_count);
    assign n_eff   = (cnt_ext > CW'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS) : cnt_ext;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign sec_idx  = sec_reg;

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sec_next   = sec_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority if (op == OP_SAMPLE) begin
                        cmd.load_x = 1'b1;
                        if (!cfg_enable || (n_eff == '0)) begin
                            // no sections run: pass-through or zero
                            cmd.phase_toggle = cfg_enable;
                            state_next       = ST_FINISH;
                        end else begin
                            step_next  = '0;
                            sec_next   = '0;
                            last_next  = SEC_W'(n_eff - CW'(1));
                            state_next = ST_ISSUE;
                        end
                    end else if (op == OP_COEF) begin
                        cmd.coef_wr = 1'b1;
                    end else if (op == OP_CLEAR) begin
                        cmd.hist_clr = 1'b1;
                    end else begin
                        // unused kind: dropped
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue   = 1'b1;
                cmd.term    = step_reg;
                cmd.acc_clr = (step_reg == TERM_GAIN);
                if (step_reg == TERM_OUT2) begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_DRAIN: begin
                if (step_reg == DRAIN_LAST) begin
                    state_next = ST_ROUND;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.wr_y = 1'b1;
                if (sec_reg == last_reg) begin
                    cmd.phase_toggle = 1'b1;
                    state_next       = ST_FINISH;
                end else begin
                    sec_next   = sec_reg + SEC_W'(1);
                    step_next  = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sec_reg   <= '0;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sec_reg   <= sec_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== src/biquad_dpath.sv =====
// Datapath for the cascaded biquad filter: stores, shared MAC, rounding and output register.
module biquad_dpath #(
    parameter int MAX_SECTIONS = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int COEF_BITS    = 18,
    parameter int SEC_W        = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  biquad_pkg::cmd_t                   cmd,
    input  logic [SEC_W-1:0]                   sec_idx,
    input  logic                               filter_en,
    input  logic [SAMPLE_BITS-1:0]             sample_in,
    input  logic [biquad_pkg::SECT_FIELD_W-1:0] coef_section,
    input  logic [biquad_pkg::SLOT_FIELD_W-1:0] coef_slot,
    input  logic [COEF_BITS-1:0]               coef_value,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [SAMPLE_BITS-1:0]             sample_out,
    output biquad_pkg::status_t                status
);
    import biquad_pkg::*;

    localparam int COEF_DEPTH = MAX_SECTIONS * SLOTS;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int HIST_DEPTH = (MAX_SECTIONS + 1) * 2;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int COEF_FRAC  = COEF_BITS - 4;
    localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W      = (PROD_W + 3 > 64) ? 64 : PROD_W + 3;

    localparam longint SMAX_L = (longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1);
    localparam longint SMIN_L = -SMAX_L - longint'(1);
    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(SMAX_L);
    localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(SMIN_L);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(longint'(1) <<< (COEF_FRAC - 1));

    // Stores
    logic [COEF_BITS-1:0]   coef_mem [COEF_DEPTH];
    logic [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]  hist_vld_reg;

    // Sample path registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          phase_reg;

    // MAC pipeline
    logic                          s1_valid_reg;
    logic                          s1_x_reg;
    logic signed [COEF_BITS-1:0]   coef_q_reg;
    logic [SAMPLE_BITS-1:0]        hist_q_reg;
    logic                          hist_v_q_reg;
    logic                          s2_valid_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_data_reg;

    logic                          coef_in_range;
    logic [COEF_AW-1:0]            coef_waddr;
    logic [COEF_AW-1:0]            coef_raddr;
    logic [1:0]                    hist_roff;
    logic [HIST_AW-1:0]            hist_base;
    logic [HIST_AW-1:0]            hist_raddr;
    logic                          wr_x;
    logic                          hist_we;
    logic [HIST_AW-1:0]            hist_waddr;
    logic [SAMPLE_BITS-1:0]        hist_wdata;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [PROD_W-1:0]      mul_p;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [ACC_W-1:0]       shifted;
    logic signed [ACC_W-1:0]       clamped;

    // Coefficient write address; out-of-range section or slot is dropped
    assign coef_in_range = (int'(coef_section) < MAX_SECTIONS) && (int'(coef_slot) < SLOTS);
    assign coef_waddr    = COEF_AW'(coef_section) * COEF_AW'(SLOTS) + COEF_AW'(coef_slot);
    assign coef_raddr    = COEF_AW'(sec_idx) * COEF_AW'(SLOTS) + COEF_AW'(cmd.term);

    // History offset inside the section's window: {output pair, entry}
    always_comb begin
        unique case (cmd.term)
            TERM_IN1:  hist_roff = {1'b0, phase_reg};
            TERM_IN2:  hist_roff = {1'b0, ~phase_reg};
            TERM_OUT1: hist_roff = {1'b1, phase_reg};
            TERM_OUT2: hist_roff = {1'b1, ~phase_reg};
            default:   hist_roff = 2'b00;
        endcase
    end

    assign hist_base  = HIST_AW'({sec_idx, 1'b0});
    assign hist_raddr = hist_base + HIST_AW'(hist_roff);

    // Input lag2 entry takes x once its old value has been read; output lag2 takes y
    assign wr_x       = cmd.issue && (cmd.term == TERM_OUT2);
    assign hist_we    = wr_x || cmd.wr_y;
    assign hist_waddr = wr_x ? (hist_base + HIST_AW'({1'b0, ~phase_reg}))
                             : (hist_base + HIST_AW'({1'b1, ~phase_reg}));
    assign hist_wdata = wr_x ? x_reg : y_reg;

    // Coefficient memory
    always_ff @(posedge aclk) begin
        if (cmd.coef_wr && coef_in_range) begin
            coef_mem[coef_waddr] <= coef_value;
        end
        if (cmd.issue) begin
            coef_q_reg <= coef_mem[coef_raddr];
        end
    end

    // History memory
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (cmd.issue) begin
            hist_q_reg <= hist_mem[hist_raddr];
        end
    end

    // History valid bits: an entry not written since clear reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
            hist_v_q_reg <= 1'b0;
        end else begin
            if (cmd.hist_clr) begin
                hist_vld_reg <= '0;
            end else if (hist_we) begin
                hist_vld_reg[hist_waddr] <= 1'b1;
            end
            if (cmd.issue) begin
                hist_v_q_reg <= hist_vld_reg[hist_raddr];
            end
        end
    end

    // Multiply stage
    assign mul_a = s1_x_reg ? x_reg : (hist_v_q_reg ? $signed(hist_q_reg) : '0);
    assign mul_p = mul_a * coef_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_x_reg <= (cmd.term == TERM_GAIN);
        prod_reg <= mul_p;
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (s2_valid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round half up at coefficient scale, floor shift, clamp to the sample range
    assign rnd     = acc_reg + HALF;
    assign shifted = rnd >>> COEF_FRAC;
    assign clamped = (shifted > SMAX) ? SMAX : ((shifted < SMIN) ? SMIN : shifted);

    always_ff @(posedge aclk) begin
        if (cmd.round_en) begin
            y_reg <= clamped[SAMPLE_BITS-1:0];
        end
        if (cmd.load_x) begin
            x_reg <= filter_en ? $signed(sample_in) : '0;
        end else if (cmd.wr_y) begin
            x_reg <= y_reg;
        end
    end

    // History phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else if (cmd.phase_toggle) begin
            phase_reg <= ~phase_reg;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= x_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sample_out      = out_data_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.phase    = phase_reg;

endmodule

// ===== src/cascaded_biquad_iir_filter_core.sv =====
// Top level of the cascaded biquad IIR filter: stream ports, register port, control and datapath.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tuser: op; s_tdata: sample_in, coef_section,
//                                      coef_slot, coef_value
//  m_        out  m_tvalid/m_tready    m_tdata: sample_out
//  APB       in   psel/penable/pready  reg 0 filter_enabled, reg 1 section_count
//
// Coefficient write, history clear and unused kinds are handled in the idle state.
// A sample skips the sections when the filter is disabled or no section is active, else
// it runs the n active sections in turn: one shared multiplier and one history read port
// give per section the issue of the five MAC terms, a pipeline drain, a round and a write-back.
// Reset clears control, the registers, the history phase and the history valid bits
// (history reads as zero at once); coefficients are undefined until written.
// A result waits in the output register while the next item is taken; a following
// sample then holds in its final cycle until the earlier result is transferred.
module cascaded_biquad_iir_filter_core #(
    parameter int MAX_SECTIONS = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int COEF_BITS    = 18
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_BITS + biquad_pkg::SECT_FIELD_W + biquad_pkg::SLOT_FIELD_W
                   + COEF_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample_in, coef_section,
                                                              // coef_slot, coef_value, zero fill
    input  logic [biquad_pkg::OP_W-1:0]             s_tuser,  // op
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata, // sample_out, zero fill
    // register port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [2:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import biquad_pkg::*;

    localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int M_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SECT_LO   = SAMPLE_BITS;
    localparam int SLOT_LO   = SECT_LO + SECT_FIELD_W;
    localparam int COEF_LO   = SLOT_LO + SLOT_FIELD_W;

    logic               en_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               cfg_wr;

    cmd_t               cmd;
    status_t            dp_status;
    logic [SEC_W-1:0]   sec_idx;
    logic [SAMPLE_BITS-1:0] dp_sample_out;

    // Register port: writes complete in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg    <= 1'b0;
            count_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ENABLE: en_reg    <= pwdata[0];
                REG_COUNT:  count_reg <= pwdata[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_COUNT) ? 32'(count_reg) : 32'(en_reg);

    biquad_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SEC_W        (SEC_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .op         (s_tuser),
        .cfg_enable (en_reg),
        .cfg_count  (count_reg),
        .status     (dp_status),
        .cmd        (cmd),
        .sec_idx    (sec_idx)
    );

    biquad_dpath #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COEF_BITS    (COEF_BITS),
        .SEC_W        (SEC_W)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sec_idx      (sec_idx),
        .filter_en    (en_reg),
        .sample_in    (s_tdata[SAMPLE_BITS-1:0]),
        .coef_section (s_tdata[SLOT_LO-1:SECT_LO]),
        .coef_slot    (s_tdata[COEF_LO-1:SLOT_LO]),
        .coef_value   (s_tdata[COEF_LO+COEF_BITS-1:COEF_LO]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .sample_out   (dp_sample_out),
        .status       (dp_status)
    );

    assign m_tdata = M_TDATA_W'(dp_sample_out);

    // A result is never loaded over one that has not been transferred
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded while output register still holds one");

    // A sample keeps the input side closed until its result is produced
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_SAMPLE)) |=> !s_tready)
        else $error("input accepted while a sample is in progress");

    // The history phase moves only on a finished sample while the filter is enabled
    a_phase_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_status.phase != $past(dp_status.phase)) |-> $past(cmd.phase_toggle))
        else $error("history phase changed without a finished sample");

endmodule
